>>> design/ptt_pkg.sv
package ptt_pkg;

    // Table geometry
    localparam int MAX_TIMERS   = 8;
    localparam int HANDLER_BITS = 8;
    localparam int IDX_W        = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W        = $clog2(MAX_TIMERS + 1);

    // Field widths of the channels
    localparam int CMD_W    = 2;
    localparam int PERIOD_W = 16;
    localparam int ID_W     = 8;
    localparam int KIND_W   = 2;

    typedef logic [HANDLER_BITS-1:0] hid_t;
    typedef logic [PERIOD_W-1:0]     period_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [CNT_W-1:0]        cnt_t;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_FIRE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_ADD,
        ST_REL_SEARCH,
        ST_REL_SHIFT,
        ST_RESP
    } state_t;

endpackage

>>> design/ptt_cmd_if.sv
interface ptt_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [ptt_pkg::CMD_W-1:0]      command;
    logic [ptt_pkg::PERIOD_W-1:0]   period;
    logic [ptt_pkg::ID_W-1:0]       handler_id;

    modport source (output valid, output command, output period, output handler_id,
                    input ready);
    modport sink   (input valid, input command, input period, input handler_id,
                    output ready);
endinterface

>>> design/ptt_res_if.sv
interface ptt_res_if;
    logic                           valid;
    logic                           ready;
    logic [ptt_pkg::KIND_W-1:0]     kind;
    logic [ptt_pkg::ID_W-1:0]       fired_id;
    logic                           success;
    logic                           last;

    modport source (output valid, output kind, output fired_id, output success,
                    output last, input ready);
    modport sink   (input valid, input kind, input fired_id, input success,
                    input last, output ready);
endinterface

>>> design/periodic_timer_table.sv
// Periodic timer table: one entry per cycle through a shared decrement/compare unit,
// unless a fire waits on a back-pressured result beat. Tick walks the live entries.
// Add writes the new entry, then responds. Release searches, then shifts the rest down.
// One command at a time; a new command is taken once the walk is done, even while
// the last result beat still waits. Reset clears the sequencer, count and result reg.
module periodic_timer_table
(
    input  logic          clk,
    input  logic          rst_n,
    ptt_cmd_if.sink       cmd,
    ptt_res_if.source     res
);

    // Entry storage (entries above the count are never used)
    ptt_pkg::period_t period_mem [ptt_pkg::MAX_TIMERS];
    ptt_pkg::period_t cd_mem     [ptt_pkg::MAX_TIMERS];
    ptt_pkg::hid_t    hid_mem    [ptt_pkg::MAX_TIMERS];

    ptt_pkg::state_t  state_reg, state_next;
    ptt_pkg::cnt_t    idx_reg, idx_next;
    ptt_pkg::cnt_t    count_reg, count_next;
    ptt_pkg::period_t cper_reg, cper_next;
    ptt_pkg::hid_t    chid_reg, chid_next;
    logic [ptt_pkg::KIND_W-1:0] rkind_reg, rkind_next;
    logic             rok_reg, rok_next;
    logic             pend_valid_reg, pend_valid_next;
    ptt_pkg::hid_t    pend_id_reg, pend_id_next;

    logic                        out_valid_reg, out_valid_next;
    logic [ptt_pkg::KIND_W-1:0]  out_kind_reg, out_kind_next;
    logic [ptt_pkg::ID_W-1:0]    out_id_reg, out_id_next;
    logic                        out_ok_reg, out_ok_next;
    logic                        out_last_reg, out_last_next;

    // Entry write port
    logic             wr_en;
    ptt_pkg::idx_t    wr_addr;
    ptt_pkg::period_t wr_per;
    ptt_pkg::period_t wr_cd;
    ptt_pkg::hid_t    wr_hid;

    // Shared read port and arithmetic
    ptt_pkg::cnt_t    nxt_idx;
    ptt_pkg::cnt_t    rd_idx;
    ptt_pkg::idx_t    rd_addr;
    ptt_pkg::period_t rd_per_reg;
    ptt_pkg::period_t rd_cd_reg;
    ptt_pkg::hid_t    rd_hid_reg;
    ptt_pkg::period_t cd_dec;
    logic             in_range;
    logic             fire;
    logic             out_free;

    // Read data is registered: fetch the entry the next cycle will work on
    assign nxt_idx  = idx_reg + 1'b1;
    assign rd_idx   = (state_next == ptt_pkg::ST_REL_SHIFT) ? idx_next + 1'b1 : idx_next;
    assign rd_addr  = rd_idx[ptt_pkg::IDX_W-1:0];
    assign cd_dec   = rd_cd_reg - 1'b1;
    assign in_range = (idx_reg < count_reg);
    assign fire     = (rd_per_reg != '0) && (cd_dec == '0);
    assign out_free = !out_valid_reg || res.ready;

    assign cmd.ready    = (state_reg == ptt_pkg::ST_IDLE);
    assign res.valid    = out_valid_reg;
    assign res.kind     = out_kind_reg;
    assign res.fired_id = out_id_reg;
    assign res.success  = out_ok_reg;
    assign res.last     = out_last_reg;

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        cper_next       = cper_reg;
        chid_next       = chid_reg;
        rkind_next      = rkind_reg;
        rok_next        = rok_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;

        out_valid_next  = out_valid_reg && !res.ready;
        out_kind_next   = out_kind_reg;
        out_id_next     = out_id_reg;
        out_ok_next     = out_ok_reg;
        out_last_next   = out_last_reg;

        wr_en   = 1'b0;
        wr_addr = idx_reg[ptt_pkg::IDX_W-1:0];
        wr_per  = rd_per_reg;
        wr_cd   = rd_cd_reg;
        wr_hid  = rd_hid_reg;

        case (state_reg)
            ptt_pkg::ST_IDLE:
            begin
                idx_next = '0;
                if (cmd.valid)
                begin
                    cper_next = cmd.period;
                    chid_next = ptt_pkg::hid_t'(cmd.handler_id);
                    case (cmd.command)
                        ptt_pkg::CMD_TICK:    state_next = ptt_pkg::ST_TICK;
                        ptt_pkg::CMD_ADD:     state_next = ptt_pkg::ST_ADD;
                        ptt_pkg::CMD_RELEASE: state_next = ptt_pkg::ST_REL_SEARCH;
                        default:              state_next = ptt_pkg::ST_IDLE;
                    endcase
                end
            end

            // Walk the live entries; one fire is held back to learn which is last
            ptt_pkg::ST_TICK:
            begin
                if (in_range)
                begin
                    if (!(fire && pend_valid_reg && !out_free))
                    begin
                        wr_en = 1'b1;
                        if (rd_per_reg != '0)
                        begin
                            wr_cd = fire ? rd_per_reg : cd_dec;
                        end
                        if (fire)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_kind_next  = ptt_pkg::KIND_FIRE;
                                out_id_next    = ptt_pkg::ID_W'(pend_id_reg);
                                out_ok_next    = 1'b1;
                                out_last_next  = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_id_next    = rd_hid_reg;
                        end
                        idx_next = nxt_idx;
                    end
                end
                else if (!pend_valid_reg)
                begin
                    state_next = ptt_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = ptt_pkg::KIND_FIRE;
                    out_id_next     = ptt_pkg::ID_W'(pend_id_reg);
                    out_ok_next     = 1'b1;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ptt_pkg::ST_IDLE;
                end
            end

            // Append at the end of the table
            ptt_pkg::ST_ADD:
            begin
                rkind_next = ptt_pkg::KIND_ADD;
                rok_next   = 1'b0;
                if (count_reg < ptt_pkg::CNT_W'(ptt_pkg::MAX_TIMERS))
                begin
                    wr_en      = 1'b1;
                    wr_addr    = count_reg[ptt_pkg::IDX_W-1:0];
                    wr_per     = cper_reg;
                    wr_cd      = cper_reg;
                    wr_hid     = chid_reg;
                    count_next = count_reg + 1'b1;
                    rok_next   = 1'b1;
                end
                state_next = ptt_pkg::ST_RESP;
            end

            // Find the first entry with the id
            ptt_pkg::ST_REL_SEARCH:
            begin
                rkind_next = ptt_pkg::KIND_RELEASE;
                rok_next   = 1'b0;
                if (!in_range)
                begin
                    state_next = ptt_pkg::ST_RESP;
                end
                else if (rd_hid_reg == chid_reg)
                begin
                    state_next = ptt_pkg::ST_REL_SHIFT;
                end
                else
                begin
                    idx_next = nxt_idx;
                end
            end

            // Close the gap, one entry per cycle, then clear the top slot
            ptt_pkg::ST_REL_SHIFT:
            begin
                wr_en = 1'b1;
                if (nxt_idx < count_reg)
                begin
                    idx_next = nxt_idx;
                end
                else
                begin
                    wr_per     = '0;
                    wr_cd      = '0;
                    wr_hid     = '0;
                    count_next = count_reg - 1'b1;
                    rok_next   = 1'b1;
                    state_next = ptt_pkg::ST_RESP;
                end
            end

            // Single response beat for add or release
            ptt_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = rkind_reg;
                    out_id_next    = '0;
                    out_ok_next    = rok_reg;
                    out_last_next  = 1'b1;
                    state_next     = ptt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ptt_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ptt_pkg::ST_IDLE;
            idx_reg        <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cper_reg      <= cper_next;
        chid_reg      <= chid_next;
        rkind_reg     <= rkind_next;
        rok_reg       <= rok_next;
        pend_id_reg   <= pend_id_next;
        out_kind_reg  <= out_kind_next;
        out_id_reg    <= out_id_next;
        out_ok_reg    <= out_ok_next;
        out_last_reg  <= out_last_next;
    end

    // Entry storage write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            period_mem[wr_addr] <= wr_per;
            cd_mem[wr_addr]     <= wr_cd;
            hid_mem[wr_addr]    <= wr_hid;
        end
        rd_per_reg <= period_mem[rd_addr];
        rd_cd_reg  <= cd_mem[rd_addr];
        rd_hid_reg <= hid_mem[rd_addr];
    end

endmodule

>>> verif/tb_periodic_timer_table.sv
`timescale 1ns / 100ps

module tb_periodic_timer_table;
    import ptt_pkg::*;

    // Command value with no meaning to the block; it must be dropped silently
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 105;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   fired_id;
        logic              success;
        logic              last;
    } result_beat_t;

    // Shadow of the timer table plus the queue of result beats still owed
    class timer_table_scoreboard;
        period_t      reload_val[MAX_TIMERS];
        period_t      remaining[MAX_TIMERS];
        hid_t         owner[MAX_TIMERS];
        int           live_entries;
        result_beat_t due_beats[$];
        int           errors;
        int           beats_checked;
        int           fires;
        int           ticks;
        int           adds;
        int           releases;
        int           ignored;

        function new();
            for (int i = 0; i < MAX_TIMERS; i++)
            begin
                reload_val[i] = '0;
                remaining[i]  = '0;
                owner[i]      = '0;
            end
            live_entries  = 0;
            errors        = 0;
            beats_checked = 0;
            fires         = 0;
            ticks         = 0;
            adds          = 0;
            releases      = 0;
            ignored       = 0;
        endfunction

        // Update the shadow table for an accepted command, queue its beats
        function void note_command(logic [CMD_W-1:0] op, period_t per, logic [ID_W-1:0] id);
            hid_t         key;
            result_beat_t beat;
            result_beat_t held;
            bit           have_held;
            bit           found;
            int           i;
            key       = id[HANDLER_BITS-1:0];
            have_held = 1'b0;
            found     = 1'b0;
            case (op)
                CMD_TICK:
                begin
                    ticks++;
                    for (i = 0; i < live_entries; i++)
                    begin
                        if (reload_val[i] != '0)
                        begin
                            remaining[i] = remaining[i] - 1'b1;
                            if (remaining[i] == '0)
                            begin
                                remaining[i]  = reload_val[i];
                                // hold each fire back one step so the final one gets last
                                if (have_held)
                                    due_beats.push_back(held);
                                held.kind     = KIND_FIRE;
                                held.fired_id = ID_W'(owner[i]);
                                held.success  = 1'b1;
                                held.last     = 1'b0;
                                have_held     = 1'b1;
                            end
                        end
                    end
                    if (have_held)
                    begin
                        held.last = 1'b1;
                        due_beats.push_back(held);
                    end
                end
                CMD_ADD:
                begin
                    adds++;
                    if (live_entries < MAX_TIMERS)
                    begin
                        reload_val[live_entries] = per;
                        remaining[live_entries]  = per;
                        owner[live_entries]      = key;
                        live_entries++;
                        found = 1'b1;
                    end
                    beat.kind     = KIND_ADD;
                    beat.fired_id = '0;
                    beat.success  = found;
                    beat.last     = 1'b1;
                    due_beats.push_back(beat);
                end
                CMD_RELEASE:
                begin
                    releases++;
                    for (i = 0; i < live_entries && !found; i++)
                    begin
                        if (owner[i] == key)
                            found = 1'b1;
                    end
                    if (found)
                    begin
                        // i is one past the match; close the gap from there
                        for (i = i - 1; i + 1 < live_entries; i++)
                        begin
                            reload_val[i] = reload_val[i+1];
                            remaining[i]  = remaining[i+1];
                            owner[i]      = owner[i+1];
                        end
                        reload_val[i] = '0;
                        remaining[i]  = '0;
                        owner[i]      = '0;
                        live_entries--;
                    end
                    beat.kind     = KIND_RELEASE;
                    beat.fired_id = '0;
                    beat.success  = found;
                    beat.last     = 1'b1;
                    due_beats.push_back(beat);
                end
                default:
                    ignored++;
            endcase
        endfunction

        // Compare one accepted result beat with the oldest one owed
        function void check_result(result_beat_t got);
            result_beat_t want;
            if (due_beats.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat kind=%0d id=%0d success=%0d last=%0d",
                         $time, got.kind, got.fired_id, got.success, got.last);
                return;
            end
            want = due_beats.pop_front();
            beats_checked++;
            if (want.kind == KIND_FIRE)
                fires++;
            if (got.kind !== want.kind)
            begin
                errors++;
                $display("%0t: kind expected %0d, actual %0d", $time, want.kind, got.kind);
            end
            if (got.fired_id !== want.fired_id)
            begin
                errors++;
                $display("%0t: fired_id expected %0d, actual %0d",
                         $time, want.fired_id, got.fired_id);
            end
            if (got.success !== want.success)
            begin
                errors++;
                $display("%0t: success expected %0d, actual %0d",
                         $time, want.success, got.success);
            end
            if (got.last !== want.last)
            begin
                errors++;
                $display("%0t: last expected %0d, actual %0d", $time, want.last, got.last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ptt_cmd_if cmd_bus();
    ptt_res_if res_bus();

    timer_table_scoreboard sb;

    int sender_calm;
    int sink_calm;
    int idle_cycles;

    periodic_timer_table u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .res   (res_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Idle length for one beat; now and then a run of back-to-back beats
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
            calm = $urandom_range(5, 20);
        return $urandom_range(0, 17);
    endfunction

    // Present one command beat and wait for it to be taken
    task automatic send_command(logic [CMD_W-1:0] op, period_t per, logic [ID_W-1:0] id);
        int gap;
        gap = draw_gap(sender_calm);
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.command    <= op;
        cmd_bus.period     <= per;
        cmd_bus.handler_id <= id;
        do
            @(posedge clk);
        while (cmd_bus.ready !== 1'b1);
        sb.note_command(op, per, id);
    endtask

    // Edges of the fields, each command, full table, duplicates, absent ids
    task automatic run_directed();
        send_command(CMD_TICK,    16'd0,     8'd0);     // empty table, no fire
        send_command(CMD_RELEASE, 16'd0,     8'd0);     // nothing to release
        send_command(CMD_ADD,     16'd1,     8'hFF);
        send_command(CMD_ADD,     16'd0,     8'h00);    // never fires
        send_command(CMD_ADD,     16'hFFFF,  8'h80);
        send_command(CMD_ADD,     16'd2,     8'h11);
        send_command(CMD_ADD,     16'd1,     8'h11);    // duplicate id
        send_command(CMD_ADD,     16'd3,     8'h5A);
        send_command(CMD_ADD,     16'd2,     8'h01);
        send_command(CMD_ADD,     16'd1,     8'hA5);    // table now full
        send_command(CMD_ADD,     16'd4,     8'h77);    // rejected
        send_command(CMD_TICK,    16'hFFFF,  8'hFF);
        send_command(CMD_TICK,    16'd0,     8'd0);
        send_command(CMD_TICK,    16'h5555,  8'hAA);
        send_command(CMD_RELEASE, 16'd0,     8'h11);    // first of the pair only
        send_command(CMD_RELEASE, 16'd0,     8'h33);    // absent
        send_command(CMD_UNUSED,  16'hFFFF,  8'hFF);    // dropped
        send_command(CMD_TICK,    16'd0,     8'd0);
        send_command(CMD_RELEASE, 16'd0,     8'hFF);    // head entry
        send_command(CMD_RELEASE, 16'd0,     8'hA5);    // tail entry
        send_command(CMD_TICK,    16'd0,     8'd0);
        send_command(CMD_ADD,     16'd1,     8'h42);
        send_command(CMD_TICK,    16'd0,     8'd0);
    endtask

    // Mostly live traffic on a busy table, with stray commands mixed in
    task automatic run_random(int items);
        int      sent;
        int      pick;
        period_t per;
        logic [ID_W-1:0] id;
        sent = 0;
        while (sent < items)
        begin
            pick = $urandom_range(0, 99);
            per  = period_t'($urandom);
            id   = ID_W'($urandom);
            if (pick < 45)
            begin
                send_command(CMD_TICK, per, id);
                sent++;
            end
            else if (pick < 70)
            begin
                case ($urandom_range(0, 9))
                    0:       per = '0;
                    1:       per = period_t'($urandom_range(9, 300));
                    2:       ;
                    default: per = period_t'($urandom_range(1, 8));
                endcase
                if (sb.live_entries > 0 && $urandom_range(0, 1) == 0)
                    id = ID_W'(sb.owner[$urandom_range(0, sb.live_entries - 1)]);
                send_command(CMD_ADD, per, id);
                sent++;
            end
            else if (pick < 92)
            begin
                if (sb.live_entries > 0 && $urandom_range(0, 4) != 0)
                    id = ID_W'(sb.owner[$urandom_range(0, sb.live_entries - 1)]);
                send_command(CMD_RELEASE, per, id);
                sent++;
            end
            else if (pick < 97)
            begin
                send_command(CMD_TICK, per, id);
                sent++;
            end
            else
                send_command(CMD_UNUSED, per, id);
        end
    endtask

    // Result side: random stall before each beat, then take it and check it
    initial
    begin
        int           stall;
        result_beat_t got;
        res_bus.ready = 1'b0;
        sink_calm     = 0;
        do
            @(posedge clk);
        while (rst_n !== 1'b1);
        forever
        begin
            stall = draw_gap(sink_calm);
            if (stall > 0)
            begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (res_bus.valid !== 1'b1);
            got.kind     = res_bus.kind;
            got.fired_id = res_bus.fired_id;
            got.success  = res_bus.success;
            got.last     = res_bus.last;
            sb.check_result(got);
        end
    end

    // Watchdog: ends the run when neither channel moves for too long
    initial
    begin
        idle_cycles = 0;
        do
            @(posedge clk);
        while (rst_n !== 1'b1);
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1) ||
                (res_bus.valid === 1'b1 && res_bus.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no beat on either channel for %0d cycles", $time, STALL_LIMIT);
        $display("** periodic_timer_table: FAILED **");
        $finish;
    end

    // Main sequence
    initial
    begin
        sb                 = new();
        sender_calm        = 0;
        rst_n              = 1'b0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.command    = CMD_TICK;
        cmd_bus.period     = '0;
        cmd_bus.handler_id = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random(RANDOM_ITEMS);
        cmd_bus.valid <= 1'b0;

        // drain owed beats, then give the block time to show any stray ones
        while (sb.due_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d ticks, %0d adds, %0d releases and %0d dropped commands.",
                 sb.ticks, sb.adds, sb.releases, sb.ignored);
        $display("Checked %0d result beats (%0d timer fires), %0d mismatches.",
                 sb.beats_checked, sb.fires, sb.errors);
        if (sb.errors == 0)
            $display("** periodic_timer_table: PASSED **");
        else
            $display("** periodic_timer_table: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
design/ptt_pkg.sv
design/ptt_cmd_if.sv
design/ptt_res_if.sv
design/periodic_timer_table.sv
verif/tb_periodic_timer_table.sv
